// File: rtl/mgbps_pkg.sv
// mgbps_pkg: shared widths, command codes and the pixel cell layout
// for the masked gain burst pixel summer; no dependencies

package mgbps_pkg;

  localparam int PIX_W   = 20;
  localparam int PIXELS  = 1 << PIX_W;
  localparam int NPIX_W  = PIX_W + 1;
  localparam int CMD_W   = 2;
  localparam int VAL_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = VAL_W + GAIN_W;
  localparam int SUM_W   = 40;
  localparam int BURST_W = 24;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HIT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

  localparam logic [NPIX_W-1:0] NPIX_MAX = NPIX_W'(PIXELS);
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic              mask;
    logic              touched;
    logic [GAIN_W-1:0] gain;
    logic [SUM_W-1:0]  sum;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ACC,
    ST_SCAN
  } state_t;

endpackage

// File: rtl/mgbps_in_if.sv
// mgbps_in_if: valid/ready channel carrying one input item
// depends on mgbps_pkg

interface mgbps_in_if;
  import mgbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PIX_W-1:0]  pixel_index;
  logic [VAL_W-1:0]  hit_value;
  logic              mask_bit;
  logic [GAIN_W-1:0] gain;

  modport source (output valid, command, pixel_index, hit_value, mask_bit, gain,
                  input ready);
  modport sink   (input valid, command, pixel_index, hit_value, mask_bit, gain,
                  output ready);
endinterface

// File: rtl/mgbps_out_if.sv
// mgbps_out_if: valid/ready channel carrying one result item
// depends on mgbps_pkg

interface mgbps_out_if;
  import mgbps_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [PIX_W-1:0]   out_pixel;
  logic [BURST_W-1:0] burst_number;
  logic [SUM_W-1:0]   pixel_sum;

  modport source (output valid, found, out_pixel, burst_number, pixel_sum,
                  input ready);
  modport sink   (input valid, found, out_pixel, burst_number, pixel_sum,
                  output ready);
endinterface

// File: rtl/mgbps_ram.sv
// mgbps_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module mgbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/masked_gain_burst_pixel_summer.sv
// masked_gain_burst_pixel_summer: a hit goes through read, multiply, accumulate, write back;
// masked hits skip the accumulate, out-of-range or unused items are dropped, and a drain scans
// entry by entry; one item in flight at a time; the single cell memory port pair sets the rate
// result held in an output register, loads and hits taken while it waits, drains are not
// rst_n synchronous: clearing pass zeroes all 1048576 cells, no item taken meanwhile
// depends on mgbps_pkg, mgbps_in_if, mgbps_out_if, mgbps_ram

module masked_gain_burst_pixel_summer (
  input  logic                         clk,
  input  logic                         rst_n,
  mgbps_in_if.sink                     in_ch,
  mgbps_out_if.source                  out_ch,
  input  logic                         cfg_wr_en,
  input  logic [mgbps_pkg::NPIX_W-1:0] cfg_wr_data
);
  import mgbps_pkg::*;

  // control state
  state_t               state_r, state_nxt;
  logic [PIX_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [NPIX_W-1:0]    n_r;             // live pixel count, already clamped
  logic [PIX_W-1:0]     scan_ptr_r, scan_ptr_nxt;
  logic [BURST_W-1:0]   burst_r, burst_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // item and datapath registers
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [PIX_W-1:0]     pix_r, pix_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic                 imask_r, imask_nxt;
  logic [GAIN_W-1:0]    igain_r, igain_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  cell_t                cell_r, cell_nxt;
  logic [PIX_W-1:0]     chk_r, chk_nxt;  // address whose data is arriving in scan

  // output payload
  logic                 o_found_r, o_found_nxt;
  logic [PIX_W-1:0]     o_pix_r, o_pix_nxt;
  logic [BURST_W-1:0]   o_burst_r, o_burst_nxt;
  logic [SUM_W-1:0]     o_sum_r, o_sum_nxt;

  // memory port
  logic                 wr_en, rd_en;
  logic [PIX_W-1:0]     wr_addr, rd_addr;
  cell_t                wr_cell, rd_cell;
  logic [CELL_W-1:0]    rd_word;

  // decode
  logic                 out_free, acc;
  logic                 in_range, scan_live, scan_end;
  logic [SUM_W:0]       sum_wide;
  logic [NPIX_W-1:0]    cfg_n;

  mgbps_ram #(
    .WIDTH (CELL_W),
    .DEPTH (PIXELS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_cell),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_cell = cell_t'(rd_word);

  // drains need a free output register; loads and hits do not
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && ((in_ch.command != CMD_DRAIN) || out_free);
  assign acc          = in_ch.valid && in_ch.ready;
  assign in_range     = {1'b0, in_ch.pixel_index} < n_r;
  assign scan_live    = {1'b0, scan_ptr_r} < n_r;
  assign scan_end     = ({1'b0, chk_r} + NPIX_W'(1)) >= n_r;
  assign sum_wide     = {1'b0, cell_r.sum} + (SUM_W + 1)'(prod_r);

  // clamp the register to 1..PIXELS once, at write time
  always_comb begin
    priority if (cfg_wr_data == '0) begin
      cfg_n = NPIX_W'(1);
    end else if (cfg_wr_data > NPIX_MAX) begin
      cfg_n = NPIX_MAX;
    end else begin
      cfg_n = cfg_wr_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == {PIX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          priority if ((in_ch.command == CMD_LOAD || in_ch.command == CMD_HIT) && in_range) begin
            state_nxt = ST_EXEC;
          end else if (in_ch.command == CMD_DRAIN && scan_live) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EXEC: begin
        if (cmd_r == CMD_HIT && rd_cell.mask) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACC: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_cell.touched || scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory port and output register
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    scan_ptr_nxt  = scan_ptr_r;
    burst_nxt     = burst_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_nxt       = cmd_r;
    pix_nxt       = pix_r;
    val_nxt       = val_r;
    imask_nxt     = imask_r;
    igain_nxt     = igain_r;
    prod_nxt      = prod_r;
    cell_nxt      = cell_r;
    chk_nxt       = chk_r;
    o_found_nxt   = o_found_r;
    o_pix_nxt     = o_pix_r;
    o_burst_nxt   = o_burst_r;
    o_sum_nxt     = o_sum_r;
    wr_en         = 1'b0;
    wr_addr       = pix_r;
    wr_cell       = '0;
    rd_en         = 1'b0;
    rd_addr       = in_ch.pixel_index;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep every cell to zero, mask and touched included
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + PIX_W'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          cmd_nxt   = in_ch.command;
          pix_nxt   = in_ch.pixel_index;
          val_nxt   = in_ch.hit_value;
          imask_nxt = in_ch.mask_bit;
          igain_nxt = in_ch.gain;
          if ((in_ch.command == CMD_LOAD || in_ch.command == CMD_HIT) && in_range) begin
            rd_en   = 1'b1;
            rd_addr = in_ch.pixel_index;
          end
          if (in_ch.command == CMD_DRAIN) begin
            if (scan_live) begin
              rd_en   = 1'b1;
              rd_addr = scan_ptr_r;
              chk_nxt = scan_ptr_r;
            end else begin
              // scan pointer past the live count: burst is done
              out_valid_nxt = 1'b1;
              o_found_nxt   = 1'b0;
              o_pix_nxt     = '0;
              o_burst_nxt   = burst_r;
              o_sum_nxt     = '0;
              burst_nxt     = burst_r + BURST_W'(1);
              scan_ptr_nxt  = '0;
            end
          end
        end
      end
      ST_EXEC: begin
        if (cmd_r == CMD_LOAD) begin
          // calibration write keeps the running sum and touched flag
          wr_en           = 1'b1;
          wr_addr         = pix_r;
          wr_cell         = rd_cell;
          wr_cell.mask    = imask_r;
          wr_cell.gain    = igain_r;
        end else begin
          prod_nxt = PROD_W'(val_r) * PROD_W'(rd_cell.gain);
          cell_nxt = rd_cell;
        end
      end
      ST_ACC: begin
        // saturating accumulate and write back
        wr_en           = 1'b1;
        wr_addr         = pix_r;
        wr_cell         = cell_r;
        wr_cell.touched = 1'b1;
        wr_cell.sum     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
      ST_SCAN: begin
        if (rd_cell.touched) begin
          // hand out the pixel and clear its accumulator
          wr_en           = 1'b1;
          wr_addr         = chk_r;
          wr_cell         = rd_cell;
          wr_cell.touched = 1'b0;
          wr_cell.sum     = '0;
          out_valid_nxt   = 1'b1;
          o_found_nxt     = 1'b1;
          o_pix_nxt       = chk_r;
          o_burst_nxt     = burst_r;
          o_sum_nxt       = rd_cell.sum;
          scan_ptr_nxt    = chk_r;
        end else if (scan_end) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = 1'b0;
          o_pix_nxt     = '0;
          o_burst_nxt   = burst_r;
          o_sum_nxt     = '0;
          burst_nxt     = burst_r + BURST_W'(1);
          scan_ptr_nxt  = '0;
        end else begin
          // one entry per cycle: issue the next address while checking this one
          rd_en   = 1'b1;
          rd_addr = chk_r + PIX_W'(1);
          chk_nxt = chk_r + PIX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      n_r         <= NPIX_MAX;
      scan_ptr_r  <= '0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        n_r <= cfg_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pix_r     <= pix_nxt;
    val_r     <= val_nxt;
    imask_r   <= imask_nxt;
    igain_r   <= igain_nxt;
    prod_r    <= prod_nxt;
    cell_r    <= cell_nxt;
    chk_r     <= chk_nxt;
    o_found_r <= o_found_nxt;
    o_pix_r   <= o_pix_nxt;
    o_burst_r <= o_burst_nxt;
    o_sum_r   <= o_sum_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = o_found_r;
  assign out_ch.out_pixel    = o_pix_r;
  assign out_ch.burst_number = o_burst_r;
  assign out_ch.pixel_sum    = o_sum_r;

  // no item taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready)
    else $error("item accepted during clearing pass");

  // read and write never collide on one cell
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("read and write to the same cell in one cycle");

  // a drained burst reports no pixel and no sum
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_found_r |-> o_sum_r == '0 && o_pix_r == '0)
    else $error("empty drain result carries data");

  // the scan never looks beyond the live pixel count
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> {1'b0, chk_r} < n_r)
    else $error("scan address beyond live pixel count");

  // a new result is only loaded into a free output register
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(o_burst_r))
    else $error("pending result overwritten");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for masked_gain_burst_pixel_summer, drives load, hit and drain
// items with random gaps and stalls, predicts every drain result and compares it
// depends on mgbps_pkg, mgbps_in_if, mgbps_out_if and the block itself

module tb_top;
  import mgbps_pkg::*;

  // unused command code, the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // idle cycles allowed after the last result before touching the register
  localparam int SETTLE_CYCLES = 16;
  // room for the clearing pass, full-size drain scans, plus slack for slow items
  localparam int unsigned LIMIT_CYCLES = 12_000_000;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PIX_W-1:0]  pixel;
    logic [VAL_W-1:0]  value;
    logic              mask;
    logic [GAIN_W-1:0] gain;
  } pixel_item_t;

  typedef struct packed {
    logic               found;
    logic [PIX_W-1:0]   pixel;
    logic [BURST_W-1:0] burst;
    logic [SUM_W-1:0]   sum;
  } drain_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [NPIX_W-1:0]   cfg_wr_data;

  mgbps_in_if  in_ch ();
  mgbps_out_if out_ch ();

  masked_gain_burst_pixel_summer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // items waiting for the driver, and drain results still owed by the block
  pixel_item_t   queued_pixel_items [$];
  drain_result_t awaited_drains [$];
  int unsigned   items_queued = 0;
  int unsigned   items_taken = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  // predicted block state, zero at reset like the block's own stores
  bit                cal_mask [PIXELS];
  bit [GAIN_W-1:0]   cal_gain [PIXELS];
  bit [SUM_W-1:0]    burst_sum [PIXELS];
  bit                pix_touched [PIXELS];
  bit [PIX_W-1:0]    scan_at = '0;
  bit [BURST_W-1:0]  burst_no = '0;
  int unsigned       live_pixels = PIXELS;
  bit                last_drain_found;

  // gap shaping: calm stretches run with no idling at all
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  pixel_item_t shown_item;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll == 2) return GAIN_W'(16'h4000);  // unity gain in q2.14
    return GAIN_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  function automatic void queue_item(logic [CMD_W-1:0] cmd, int unsigned pix,
                                     int unsigned val, bit msk, int unsigned gn);
    pixel_item_t it;
    it.command = cmd;
    it.pixel   = PIX_W'(pix);
    it.value   = VAL_W'(val);
    it.mask    = msk;
    it.gain    = GAIN_W'(gn);
    queued_pixel_items.insert(queued_pixel_items.size(), it);
    items_queued++;
  endfunction

  // effect of one accepted item on the pixel stores, drains forecast their result
  task automatic predict_pixel_item(input pixel_item_t it);
    drain_result_t res;
    logic [SUM_W:0] acc;
    int unsigned    p;
    p = it.pixel;
    case (it.command)
      CMD_LOAD: begin
        if (p < live_pixels) begin
          cal_mask[p] = it.mask;
          cal_gain[p] = it.gain;
        end
      end
      CMD_HIT: begin
        // masked or out-of-range pixels take nothing
        if (p < live_pixels && cal_mask[p]) begin
          acc = {1'b0, burst_sum[p]} + it.value * cal_gain[p];
          burst_sum[p] = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
          pix_touched[p] = 1'b1;
        end
      end
      CMD_DRAIN: begin
        res.found = 1'b0;
        res.pixel = '0;
        res.burst = burst_no;
        res.sum   = '0;
        // walk upward from the scan pointer, only inside the live pixel range
        for (p = scan_at; p < live_pixels; p++) begin
          if (pix_touched[p]) begin
            res.found      = 1'b1;
            res.pixel      = PIX_W'(p);
            res.sum        = burst_sum[p];
            burst_sum[p]   = '0;
            pix_touched[p] = 1'b0;
            scan_at        = PIX_W'(p);
            break;
          end
        end
        // nothing left: close the burst and rewind
        if (!res.found) begin
          burst_no = burst_no + 1'b1;
          scan_at  = '0;
        end
        last_drain_found = res.found;
        awaited_drains.insert(awaited_drains.size(), res);
      end
      default: ;
    endcase
  endtask

  // item driver: one item held until taken, random gaps between items
  always @(posedge clk) begin : drive_items
    logic slot_busy;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_pixel_item(shown_item);
        items_taken++;
        if ($urandom_range(149) == 0) calm_in = !calm_in;
        in_gap = (calm_in || $urandom_range(2) != 0) ? 0 : pick_gap();
      end
      slot_busy = in_ch.valid && !in_ch.ready;
      if (!slot_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (queued_pixel_items.size() != 0) begin
          shown_item = queued_pixel_items.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.command     <= shown_item.command;
          in_ch.pixel_index <= shown_item.pixel;
          in_ch.hit_value   <= shown_item.value;
          in_ch.mask_bit    <= shown_item.mask;
          in_ch.gain        <= shown_item.gain;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each taken drain result, stalls ready at random
  always @(posedge clk) begin : watch_drains
    drain_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_drains.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected drain result: found=%0d pixel=%0d burst=%0d sum=%0h",
                     out_ch.found, out_ch.out_pixel, out_ch.burst_number, out_ch.pixel_sum);
        end else begin
          want = awaited_drains.pop_front();
          if (out_ch.found !== want.found || out_ch.out_pixel !== want.pixel ||
              out_ch.burst_number !== want.burst || out_ch.pixel_sum !== want.sum) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("drain mismatch: want found=%0d pixel=%0d burst=%0d sum=%0h, %s",
                       want.found, want.pixel, want.burst, want.sum,
                       $sformatf("got found=%0d pixel=%0d burst=%0d sum=%0h",
                                 out_ch.found, out_ch.out_pixel, out_ch.burst_number,
                                 out_ch.pixel_sum));
          end
        end
        if ($urandom_range(39) == 0) calm_out = !calm_out;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm_out && $urandom_range(3) == 0) out_stall = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sender holds off until every queued item is taken and every result is back
  task automatic wait_idle();
    @(posedge clk);
    while (items_taken != items_queued || awaited_drains.size() != 0) @(posedge clk);
  endtask

  // register write only with the block quiet, a hit may still be finishing
  task automatic write_active_pixels(input logic [NPIX_W-1:0] value);
    int unsigned n;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n = value;
    if (n < 1) n = 1;
    if (n > PIXELS) n = PIXELS;
    live_pixels = n;
  endtask

  // drain one item at a time until the block reports the burst empty
  task automatic drain_out();
    bit more;
    more = 1'b1;
    while (more) begin
      queue_item(CMD_DRAIN, $urandom, $urandom, $urandom, $urandom);
      wait_idle();
      more = last_drain_found;
    end
  endtask

  // a hot set of calibrated pixels, then a mix of hits, loads, drains and noise
  task automatic run_random_phase(input int n_items, input bit saturate);
    int unsigned hot [$];
    int unsigned pix, roll;
    int          k;
    repeat ($urandom_range(12, 1)) begin
      roll = $urandom_range(9);
      if (roll == 0) pix = live_pixels - 1;
      else if (roll == 1) pix = live_pixels + $urandom_range(4);  // just past the range
      else pix = $urandom_range(live_pixels - 1, 0);
      hot.insert(hot.size(), pix);
      queue_item(CMD_LOAD, pix, $urandom, $urandom_range(7) != 0, pick_gain());
    end
    if (saturate) begin
      // full-scale hits until the sum sticks at the top
      pix = $urandom_range(live_pixels - 1, 0);
      queue_item(CMD_LOAD, pix, $urandom, 1'b1, 16'hFFFF);
      repeat (270) queue_item(CMD_HIT, pix, 16'hFFFF, $urandom, $urandom);
    end
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      pix  = hot[$urandom_range(hot.size() - 1)];
      if (roll < 50) queue_item(CMD_HIT, pix, pick_value(), $urandom, $urandom);
      else if (roll < 58)
        queue_item(CMD_HIT, $urandom_range(PIXELS - 1), pick_value(), $urandom, $urandom);
      else if (roll < 66) queue_item(CMD_LOAD, pix, $urandom, $urandom_range(5) != 0,
                                     pick_gain());
      else if (roll < 69)
        queue_item(CMD_LOAD, $urandom_range(PIXELS - 1), $urandom, $urandom, pick_gain());
      else if (roll < 71) queue_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 94) queue_item(CMD_DRAIN, $urandom, $urandom, $urandom, $urandom);
      else repeat ($urandom_range(6, 2))
        queue_item(CMD_DRAIN, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin : run_bench
    int unsigned plan [12];
    int unsigned next_count;
    int          i;
    plan = '{0, 1, 2, 16, 5, 64, 1, 255, 1023, 37, 3, 700};
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.pixel_index = '0;
    in_ch.hit_value   = '0;
    in_ch.mask_bit    = 1'b0;
    in_ch.gain        = '0;
    out_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // full pixel range at reset: top pixel and bit patterns, left touched for the end
    queue_item(CMD_LOAD, PIXELS - 1, 0, 1'b1, 16'hFFFF);
    queue_item(CMD_HIT, PIXELS - 1, 16'hFFFF, 1'b0, 16'h0000);
    queue_item(CMD_HIT, PIXELS - 1, 16'hFFFF, 1'b1, 16'hFFFF);
    queue_item(CMD_LOAD, 20'hAAAAA, 16'h5555, 1'b0, 16'hAAAA);
    queue_item(CMD_HIT, 20'hAAAAA, 16'h5555, 1'b1, 16'h5555);    // masked pixel
    queue_item(CMD_UNUSED, 20'hFFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    queue_item(CMD_LOAD, 20'h55555, 16'hAAAA, 1'b1, 16'h5555);
    queue_item(CMD_HIT, 20'h55555, 16'hAAAA, 1'b0, 16'hAAAA);

    // small frame of eight pixels
    write_active_pixels(8);
    queue_item(CMD_LOAD, 0, 0, 1'b1, 16'h4000);
    queue_item(CMD_LOAD, 1, 0, 1'b1, 16'hFFFF);
    queue_item(CMD_LOAD, 2, 0, 1'b1, 16'h0000);
    queue_item(CMD_LOAD, 3, 0, 1'b0, 16'hFFFF);
    queue_item(CMD_LOAD, 5, 0, 1'b1, 16'h0001);
    queue_item(CMD_LOAD, 7, 0, 1'b1, 16'h8000);
    queue_item(CMD_LOAD, 8, 0, 1'b1, 16'hFFFF);       // first pixel out of range
    queue_item(CMD_LOAD, 9, 0, 1'b1, 16'hFFFF);
    queue_item(CMD_HIT, 2, 16'hFFFF, 0, 0);           // zero gain, touched with zero sum
    queue_item(CMD_HIT, 5, 16'hFFFF, 0, 0);
    queue_item(CMD_HIT, 5, 16'h0001, 0, 0);
    queue_item(CMD_HIT, 3, 16'h0007, 0, 0);           // masked
    queue_item(CMD_HIT, 8, 16'h0009, 0, 0);           // out of range
    queue_item(CMD_HIT, 1, 16'h0000, 0, 0);
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_HIT, 0, 16'hFFFF, 0, 0);           // behind the scan, next burst
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_HIT, 7, 16'hFFFF, 0, 0);
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_DRAIN, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 6, 0, 1'b1, 16'h0003);
    queue_item(CMD_HIT, 6, 16'h0002, 0, 0);           // stays touched when the frame shrinks

    // random phases over shrinking and growing frames, zero saturates to one pixel
    for (i = 0; i < 14; i++) begin
      next_count = (i < 12) ? plan[i] : $urandom_range(300, 1);
      write_active_pixels(NPIX_W'(next_count));
      run_random_phase(85, i == 5);
      if ($urandom_range(3) != 0) drain_out();
    end

    // all-ones register value saturates to the full frame, leftovers come out
    drain_out();
    write_active_pixels('1);
    drain_out();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_drains.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
